>>> hdl/skvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_pkg
// types and constants shared by the sorted key/value table
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int DEPTH      = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_LOOKUP    = 3'd0,
        KIND_ADD       = 3'd1,
        KIND_ASSIGN    = 3'd2,
        KIND_CHANGE    = 3'd3,
        KIND_TAKE      = 3'd4,
        KIND_DELETE_AT = 3'd5,
        KIND_READ_AT   = 3'd6,
        KIND_WRITE_AT  = 3'd7
    } kind_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
        logic [7:0]  index;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  position;
        logic [31:0] key_out;
        logic [31:0] value_out;
        logic [8:0]  entries;
    } rsp_t;

    // datapath commands from the controller
    typedef struct packed {
        logic load;      // capture request
        logic srch_init; // start binary search
        logic srch_step; // take one search compare
        logic rd_pos;    // read entry at pos
        logic capture;   // hold entry read at pos
        logic shift_rd;  // read neighbor for a shift
        logic shift_wr;  // write shifted entry
        logic wr_val;    // write value at pos
        logic wr_new;    // write new key and value at pos
        logic cnt_inc;
        logic cnt_dec;
        logic respond;
        logic up;        // shift direction for insert
    } cmd_t;

    typedef struct packed {
        logic srch_done;
        logic srch_wait;
        logic hit;
        logic full;
        logic idx_bad;
        logic shift_done;
    } sts_t;

endpackage

>>> hdl/skvt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module skvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> hdl/skvt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_datapath
// key and value stores, search bounds, shift pointer and result register
// ----------------------------------------------------------------------------
module skvt_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  skvt_pkg::req_t req,
    input  skvt_pkg::cmd_t cmd,
    output skvt_pkg::sts_t sts,
    output skvt_pkg::rsp_t rsp
);
    import skvt_pkg::*;

    req_t                 req_reg;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_BITS-1:0]  sp_reg, sp_next;
    logic [CNT_BITS-1:0]  mid;
    logic [ADDR_BITS-1:0] addr;
    logic                 k_we, v_we;
    logic [KEY_BITS-1:0]  k_wd, k_rd, k_hold_reg;
    logic [VALUE_BITS-1:0] v_wd, v_rd, v_hold_reg;
    logic                 rd_valid_reg;
    logic                 is_index;
    logic [CNT_BITS-1:0]  pos;
    rsp_t                 rsp_reg, rsp_next;

    assign is_index = (req_reg.kind == KIND_DELETE_AT) || (req_reg.kind == KIND_READ_AT)
                      || (req_reg.kind == KIND_WRITE_AT);
    assign pos  = is_index ? CNT_BITS'(req_reg.index) : lo_reg;
    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        addr = pos[ADDR_BITS-1:0];
        k_we = 1'b0;
        v_we = 1'b0;
        k_wd = k_hold_reg;
        v_wd = v_hold_reg;
        if (cmd.srch_step)
        begin
            addr = mid[ADDR_BITS-1:0];
        end
        else if (cmd.shift_rd)
        begin
            addr = cmd.up ? ADDR_BITS'(sp_reg - 1'b1) : ADDR_BITS'(sp_reg + 1'b1);
        end
        else if (cmd.shift_wr)
        begin
            addr = sp_reg[ADDR_BITS-1:0];
            k_we = 1'b1;
            v_we = 1'b1;
            k_wd = k_rd;
            v_wd = v_rd;
        end
        else if (cmd.wr_new)
        begin
            k_we = 1'b1;
            v_we = 1'b1;
            k_wd = req_reg.key;
            v_wd = req_reg.value;
        end
        else if (cmd.wr_val)
        begin
            v_we = 1'b1;
            v_wd = req_reg.value;
        end
    end

    skvt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_keys (
        .clk(clk), .we(k_we), .addr(addr), .wdata(k_wd), .rdata(k_rd));
    skvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_vals (
        .clk(clk), .we(v_we), .addr(addr), .wdata(v_wd), .rdata(v_rd));

    // search: a read issued on srch_step returns next cycle, then compare
    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        sp_next  = sp_reg;
        cnt_next = cnt_reg;
        if (cmd.srch_init)
        begin
            lo_next = '0;
            hi_next = cnt_reg;
        end
        else if (rd_valid_reg)
        begin
            if (k_rd < req_reg.key)
            begin
                lo_next = sp_reg + 1'b1;
            end
            else
            begin
                hi_next = sp_reg;
            end
        end
        if (cmd.srch_step)
        begin
            sp_next = mid;
        end
        if (cmd.rd_pos)
        begin
            sp_next = cmd.up ? cnt_reg : pos;
        end
        if (cmd.shift_wr)
        begin
            sp_next = cmd.up ? sp_reg - 1'b1 : sp_reg + 1'b1;
        end
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign sts.srch_done  = (lo_reg >= hi_reg) && !rd_valid_reg;
    assign sts.srch_wait  = rd_valid_reg;
    assign sts.hit        = (lo_reg < cnt_reg) && (k_hold_reg == req_reg.key);
    assign sts.full       = (cnt_reg == CNT_BITS'(DEPTH));
    assign sts.idx_bad    = CNT_BITS'(req_reg.index) >= cnt_reg;
    assign sts.shift_done = cmd.up ? (sp_reg <= pos) : (sp_reg + 1'b1 >= cnt_reg);

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_next.position  = pos[7:0];
        rsp_next.entries   = 9'(cnt_reg);
        rsp_next.key_out   = is_index ? k_hold_reg : req_reg.key;
        rsp_next.value_out = v_hold_reg;
        if (is_index)
        begin
            if (sts.idx_bad)
            begin
                rsp_next.status    = ST_BAD_INDEX;
                rsp_next.key_out   = '0;
                rsp_next.value_out = '0;
            end
            else
            begin
                rsp_next.status = ST_OK;
                if (req_reg.kind == KIND_WRITE_AT)
                begin
                    rsp_next.value_out = req_reg.value;
                end
                if (req_reg.kind == KIND_DELETE_AT)
                begin
                    rsp_next.entries = 9'(cnt_reg - 1'b1);
                end
            end
        end
        else if (sts.hit)
        begin
            rsp_next.status = (req_reg.kind == KIND_ADD) ? ST_EXISTS : ST_OK;
            if ((req_reg.kind == KIND_ASSIGN) || (req_reg.kind == KIND_CHANGE))
            begin
                rsp_next.value_out = req_reg.value;
            end
            if (req_reg.kind == KIND_TAKE)
            begin
                rsp_next.entries = 9'(cnt_reg - 1'b1);
            end
        end
        else if ((req_reg.kind == KIND_ADD) || (req_reg.kind == KIND_ASSIGN))
        begin
            rsp_next.status    = sts.full ? ST_FULL : ST_OK;
            rsp_next.value_out = sts.full ? '0 : req_reg.value;
            rsp_next.entries   = sts.full ? 9'(cnt_reg) : 9'(cnt_reg + 1'b1);
        end
        else
        begin
            rsp_next.status    = ST_NOT_FOUND;
            rsp_next.value_out = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            sp_reg       <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            sp_reg       <= sp_next;
            rd_valid_reg <= cmd.srch_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.capture)
        begin
            k_hold_reg <= k_rd;
            v_hold_reg <= v_rd;
        end
        if (cmd.respond)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(DEPTH)) else $error("count over depth");
    a_full_no_inc: assert property (@(posedge clk) disable iff (!rst_n)
        sts.full |-> !cmd.cnt_inc) else $error("insert into full table");
    a_empty_no_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !cmd.cnt_dec) else $error("delete from empty table");
`endif
endmodule

>>> hdl/skvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_ctrl
// request sequencer: search, read, shift, write, respond
// ----------------------------------------------------------------------------
module skvt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2:0]     kind,
    input  skvt_pkg::sts_t sts,
    output skvt_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done
);
    import skvt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SRCH, S_RD, S_HOLD, S_DECIDE,
        S_SH_RD, S_SH_WAIT, S_SH_WR, S_WR_NEW, S_RESP
    } state_t;

    state_t state_reg;
    logic   done_reg;
    logic   insert_reg;
    logic   is_index;
    logic   want_ins;

    assign is_index = (kind == KIND_DELETE_AT) || (kind == KIND_READ_AT)
                      || (kind == KIND_WRITE_AT);
    assign want_ins = (kind == KIND_ADD) || (kind == KIND_ASSIGN);

    always_comb
    begin
        cmd      = '0;
        cmd.up   = insert_reg;
        unique case (state_reg)
            S_IDLE:    cmd.load = start;
            S_INIT:    cmd.srch_init = 1'b1;
            S_SRCH:    cmd.srch_step = !sts.srch_done && !sts.srch_wait;
            S_RD:
            begin
                cmd.rd_pos = 1'b1;
                cmd.up     = want_ins;
            end
            S_HOLD:    cmd.capture = 1'b1;
            S_DECIDE:  cmd.respond = 1'b1;
            S_SH_RD:   cmd.shift_rd = 1'b1;
            S_SH_WAIT: cmd.shift_rd = 1'b1;
            S_SH_WR:   cmd.shift_wr = 1'b1;
            S_WR_NEW:
            begin
                cmd.wr_new  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_RESP:    cmd.cnt_dec = !insert_reg;
            default:   cmd = '0;
        endcase
        if (state_reg == S_DECIDE)
        begin
            if (is_index && !sts.idx_bad && (kind == KIND_WRITE_AT))
            begin
                cmd.wr_val = 1'b1;
            end
            if (!is_index && sts.hit
                && ((kind == KIND_ASSIGN) || (kind == KIND_CHANGE)))
            begin
                cmd.wr_val = 1'b1;
            end
        end
    end

    // the shift path raises done on leaving S_RESP, as the count is updated (take, delete) or after it (insert)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            insert_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    state_reg <= is_index ? S_RD : S_SRCH;
                end
                S_SRCH:
                begin
                    if (sts.srch_done)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:      state_reg <= S_HOLD;
                S_HOLD:    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    priority if (is_index ? (!sts.idx_bad && kind == KIND_DELETE_AT)
                                          : (sts.hit && kind == KIND_TAKE))
                    begin
                        insert_reg <= 1'b0;
                        state_reg  <= S_SH_RD;
                    end
                    else if (!is_index && !sts.hit && want_ins && !sts.full)
                    begin
                        insert_reg <= 1'b1;
                        state_reg  <= S_SH_RD;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_SH_RD:
                begin
                    state_reg <= sts.shift_done ? (insert_reg ? S_WR_NEW : S_RESP)
                                                : S_SH_WAIT;
                end
                S_SH_WAIT: state_reg <= S_SH_WR;
                S_SH_WR:   state_reg <= S_SH_RD;
                S_WR_NEW:  state_reg <= S_RESP;
                S_RESP:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.shift_wr, cmd.wr_new, cmd.wr_val}) <= 1)
        else $error("two store writes in one cycle");
`endif
endmodule

>>> hdl/sorted_key_value_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// sorted table of unique keys with values, binary searched
//
// a request beat is taken when start is high and busy is low. the result
// beat is marked on rsp by done high for one cycle; it cannot be stalled.
// kinds: lookup, add, assign, change, take, delete_at, read_at, write_at.
// keyed requests binary search the keys, one store read per search step,
// the read registered; index requests go straight to their entry. take,
// delete_at and inserts then shift entries one at a time, each shift
// reading and writing through the single store port.
// one request in flight at a time; the next may start while done is high.
// reset clears the entry count; the stores themselves are not cleared,
// and what they hold at or above the count never reaches a result.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  skvt_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output skvt_pkg::rsp_t rsp
);
    import skvt_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic [2:0] rsp_kind, kind_reg;

    skvt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(busy ? rsp_kind : req.kind),
        .sts(sts), .cmd(cmd), .busy(busy), .done(done));

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg <= req.kind;
        end
    end
    assign rsp_kind = kind_reg;

    skvt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp));
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted key/value table
//
// drives request beats through the start/busy handshake and checks each
// done beat against a behavioral table model. Stimulus covers empty, partly
// filled and full tables. It starts with directed requests, then runs random
// requests with random sender idling, and fills the table with ascending
// keys so that inserts into a full table are exercised.
// ----------------------------------------------------------------------------
module tb_top;
    import skvt_pkg::*;

    class table_scoreboard;
        logic [31:0] keys [DEPTH];
        logic [31:0] vals [DEPTH];
        int          count;
        rsp_t        pending [$];
        int          fails;

        function new();
            count = 0;
            fails = 0;
        endfunction

        function int find_slot(logic [31:0] k, output bit hit);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = count;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] < k) lo = mid + 1;
                else hi = mid;
            end
            hit = (lo < count) && (keys[lo] == k);
            return lo;
        endfunction

        function void open_gap(int pos);
            for (int i = count; i > pos; i--)
            begin
                keys[i] = keys[i-1];
                vals[i] = vals[i-1];
            end
            count++;
        endfunction

        function void close_gap(int pos);
            for (int i = pos; i + 1 < count; i++)
            begin
                keys[i] = keys[i+1];
                vals[i] = vals[i+1];
            end
            count--;
        endfunction

        function void note(req_t r);
            rsp_t e;
            bit   hit;
            int   pos;
            e = '0;
            if (r.kind <= KIND_TAKE)
            begin
                pos = find_slot(r.key, hit);
                e.key_out = r.key;
                if (hit)
                begin
                    e.value_out = vals[pos];
                    if (r.kind == KIND_ADD)
                        e.status = ST_EXISTS;
                    else if (r.kind == KIND_ASSIGN || r.kind == KIND_CHANGE)
                    begin
                        vals[pos] = r.value;
                        e.value_out = r.value;
                    end
                    else if (r.kind == KIND_TAKE)
                        close_gap(pos);
                end
                else if (r.kind == KIND_ADD || r.kind == KIND_ASSIGN)
                begin
                    if (count >= DEPTH)
                        e.status = ST_FULL;
                    else
                    begin
                        open_gap(pos);
                        keys[pos] = r.key;
                        vals[pos] = r.value;
                        e.value_out = r.value;
                    end
                end
                else
                    e.status = ST_NOT_FOUND;
                e.position = pos[7:0];
            end
            else
            begin
                e.position = r.index;
                if (r.index >= count)
                    e.status = ST_BAD_INDEX;
                else
                begin
                    e.key_out = keys[r.index];
                    e.value_out = vals[r.index];
                    if (r.kind == KIND_DELETE_AT)
                        close_gap(r.index);
                    else if (r.kind == KIND_WRITE_AT)
                    begin
                        vals[r.index] = r.value;
                        e.value_out = r.value;
                    end
                end
            end
            e.entries = count[8:0];
            pending.push_back(e);
        endfunction

        function void check(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected");
                fails++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, a.status);
                fails++;
            end
            if (a.position !== e.position)
            begin
                $error("position exp %0d got %0d", e.position, a.position);
                fails++;
            end
            if (a.key_out !== e.key_out)
            begin
                $error("key_out exp %h got %h", e.key_out, a.key_out);
                fails++;
            end
            if (a.value_out !== e.value_out)
            begin
                $error("value_out exp %h got %h", e.value_out, a.value_out);
                fails++;
            end
            if (a.entries !== e.entries)
            begin
                $error("entries exp %0d got %0d", e.entries, a.entries);
                fails++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;
    int   quiet_cycles;

    table_scoreboard sb = new();

    sorted_key_value_table_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(rsp);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 4000)
        begin
            $display("sorted_key_value_table_top verification failed");
            $finish;
        end
    end

    task automatic send(req_t r, int idle_pct);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        sb.note(r);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic op(kind_t k, logic [31:0] key, logic [31:0] val, logic [7:0] idx);
        req_t r;
        r.kind  = k;
        r.key   = key;
        r.value = val;
        r.index = idx;
        send(r, 0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic req_t pick_req();
        req_t r;
        int   w;
        w = $urandom_range(0, 99);
        if (w < 15) r.kind = KIND_LOOKUP;
        else if (w < 35) r.kind = KIND_ADD;
        else if (w < 50) r.kind = KIND_ASSIGN;
        else if (w < 60) r.kind = KIND_CHANGE;
        else if (w < 70) r.kind = KIND_TAKE;
        else if (w < 78) r.kind = KIND_DELETE_AT;
        else if (w < 90) r.kind = KIND_READ_AT;
        else r.kind = KIND_WRITE_AT;
        case ($urandom_range(0, 3))
            0: r.key = (sb.count > 0) ? sb.keys[$urandom_range(0, sb.count - 1)] : 32'd0;
            1: r.key = $urandom_range(0, 63);
            2: r.key = $urandom;
            default: r.key = (sb.count > 0) ?
                sb.keys[$urandom_range(0, sb.count - 1)] + 32'd1 : 32'hffff_ffff;
        endcase
        r.value = $urandom;
        if ($urandom_range(0, 1) && sb.count > 0)
            r.index = $urandom_range(0, sb.count - 1);
        else
            r.index = $urandom_range(0, 255);
        return r;
    endfunction

    initial
    begin
        logic [31:0] k;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table corners
        op(KIND_LOOKUP,    32'd7, 32'd0, 8'd0);
        op(KIND_TAKE,      32'd7, 32'd0, 8'd0);
        op(KIND_CHANGE,    32'd7, 32'd1, 8'd0);
        op(KIND_READ_AT,   32'd0, 32'd0, 8'd0);
        op(KIND_DELETE_AT, 32'd0, 32'd0, 8'd255);
        op(KIND_WRITE_AT,  32'd0, 32'hffff_ffff, 8'd0);
        op(KIND_ADD,       32'd0, 32'd0, 8'd0);
        op(KIND_ADD,       32'hffff_ffff, 32'hffff_ffff, 8'd0);
        op(KIND_ADD,       32'd5, 32'h1234_5678, 8'd0);
        op(KIND_ADD,       32'd5, 32'h0bad_0bad, 8'd0);
        op(KIND_ASSIGN,    32'd5, 32'haaaa_5555, 8'd0);
        op(KIND_ASSIGN,    32'd7, 32'h5555_aaaa, 8'd0);
        op(KIND_CHANGE,    32'd7, 32'h0000_ffff, 8'd0);
        op(KIND_CHANGE,    32'd9, 32'h0f0f_0f0f, 8'd0);
        op(KIND_LOOKUP,    32'd7, 32'd0, 8'd0);
        op(KIND_LOOKUP,    32'd6, 32'd0, 8'd0);
        op(KIND_READ_AT,   32'd0, 32'd0, 8'd0);
        op(KIND_READ_AT,   32'd0, 32'd0, 8'd3);
        op(KIND_WRITE_AT,  32'd0, 32'hdead_beef, 8'd1);
        op(KIND_DELETE_AT, 32'd0, 32'd0, 8'd1);
        op(KIND_TAKE,      32'hffff_ffff, 32'd0, 8'd0);
        op(KIND_TAKE,      32'd0, 32'd0, 8'd0);
        op(KIND_LOOKUP,    32'd0, 32'd0, 8'd0);
        op(KIND_READ_AT,   32'd0, 32'd0, 8'd4);

        for (int i = 0; i < 45; i++) send(pick_req(), 22);
        drain();
        for (int i = 0; i < 45; i++) send(pick_req(), 55);

        // empty the table, then fill it with ascending keys
        while (sb.count > 0)
            op(KIND_DELETE_AT, $urandom, $urandom, $urandom_range(0, sb.count - 1));
        for (int i = 0; i < DEPTH; i++)
        begin
            k = {i[7:0], 24'(($urandom))};
            op(KIND_ADD, k, $urandom, 8'd0);
        end
        op(KIND_ADD,     32'h0000_0000, 32'h1111_1111, 8'd0);
        op(KIND_ASSIGN,  32'hffff_ffff, 32'h2222_2222, 8'd0);
        op(KIND_ASSIGN,  sb.keys[128], 32'h3333_3333, 8'd0);
        op(KIND_READ_AT, 32'd0, 32'd0, 8'd255);
        op(KIND_WRITE_AT, 32'd0, 32'hffff_ffff, 8'd255);

        for (int i = 0; i < 30; i++) send(pick_req(), 0);
        drain();

        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("sorted_key_value_table_top verification clean");
        else
            $display("sorted_key_value_table_top verification failed");
        $finish;
    end
endmodule
